// ----- rtl/first_fit_block_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Shared macros for the concurrent checks of the allocator. They sample on
// clk and stay quiet while arst_n is asserted.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Field widths, operation and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ffba_pkg;

	// Field widths of the request and the response.
	localparam int REQ_W       = 11;
	localparam int ADDR_IN_W   = 11;
	localparam int START_W     = 10;
	localparam int LEN_W       = REQ_W;
	localparam int HEAP_BLOCKS_DEF = 1024;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ZERO   = 2'd1,
		ST_NOFIT  = 2'd2,
		ST_BADADR = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_MARK,
		S_LEN_CHK,
		S_RELEASE,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    clr_step;
		logic    scan_start;
		logic    scan_step;
		logic    mark_step;
		logic    len_rd;
		logic    len_clear;
		logic    rel_step;
		logic    res_load;
		status_t res_status;
		logic    res_grant;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_free;
		logic zero;
		logic too_big;
		logic bad_addr;
		logic hit;
		logic scan_last;
		logic mark_last;
		logic len_zero;
		logic rel_last;
		logic clr_last;
	} sts_t;

endpackage

// ----- rtl/ffba_req_if.sv -----
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel that carries one allocate or free request.
// ----------------------------------------------------------------------------
interface ffba_req_if
	import ffba_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [REQ_W-1:0]     req_blocks;
	logic [ADDR_IN_W-1:0] free_start;

	modport source (output valid, op, req_blocks, free_start, input ready);
	modport sink   (input valid, op, req_blocks, free_start, output ready);
endinterface

// ----- rtl/ffba_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel that carries the status and start block of a request.
// ----------------------------------------------------------------------------
interface ffba_rsp_if
	import ffba_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [START_W-1:0] start_block;

	modport source (output valid, status, start_block, input ready);
	modport sink   (input valid, status, start_block, output ready);
endinterface

// ----- rtl/ffba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator controller
// State machine that sequences the clearing pass, the first-fit scan, the
// marking and releasing sweeps and the hand-off to the response register.
// ----------------------------------------------------------------------------
module ffba_ctrl
	import ffba_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  logic rsp_ready,
	output logic rsp_valid,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t  state_q, state_d;
	status_t res_st_q, res_st_d;
	logic    grant_q, grant_d;
	logic    out_valid_q;

	// Next state and the pending result code.
	always_comb begin
		state_d  = state_q;
		res_st_d = res_st_q;
		grant_d  = grant_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				grant_d = 1'b0;
				if (sts.is_free) begin
					if (sts.bad_addr) begin
						res_st_d = ST_BADADR;
						state_d  = S_RESP;
					end else begin
						state_d = S_LEN_CHK;
					end
				end else if (sts.zero) begin
					res_st_d = ST_ZERO;
					state_d  = S_RESP;
				end else if (sts.too_big) begin
					res_st_d = ST_NOFIT;
					state_d  = S_RESP;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.hit) begin
					state_d = S_MARK;
				end else if (sts.scan_last) begin
					res_st_d = ST_NOFIT;
					state_d  = S_RESP;
				end
			end
			S_MARK: begin
				if (sts.mark_last) begin
					res_st_d = ST_OK;
					grant_d  = 1'b1;
					state_d  = S_RESP;
				end
			end
			S_LEN_CHK: begin
				if (sts.len_zero) begin
					res_st_d = ST_BADADR;
					state_d  = S_RESP;
				end else begin
					state_d = S_RELEASE;
				end
			end
			S_RELEASE: begin
				if (sts.rel_last) begin
					res_st_d = ST_OK;
					state_d  = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_valid_q || rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd            = '0;
		cmd.res_status = res_st_q;
		cmd.res_grant  = grant_q;
		req_ready      = 1'b0;
		unique case (state_q)
			S_CLEAR:   cmd.clr_step = 1'b1;
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_DECIDE: begin
				cmd.len_rd     = sts.is_free && !sts.bad_addr;
				cmd.scan_start = !sts.is_free && !sts.zero && !sts.too_big;
			end
			S_SCAN:    cmd.scan_step = 1'b1;
			S_MARK:    cmd.mark_step = 1'b1;
			S_LEN_CHK: cmd.len_clear = !sts.len_zero;
			S_RELEASE: cmd.rel_step  = 1'b1;
			S_RESP:    cmd.res_load  = !out_valid_q || rsp_ready;
			default:   cmd = '0;
		endcase
	end

	// State and response valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			res_st_q    <= ST_OK;
			grant_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			res_st_q <= res_st_d;
			grant_q  <= grant_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

// ----- rtl/ffba_dp.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Free map and length memories, the scan and sweep counters, the request
// holding registers and the response payload register.
// ----------------------------------------------------------------------------
module ffba_dp
	import ffba_pkg::*;
#(
	parameter int HEAP_BLOCKS = HEAP_BLOCKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op,
	input  logic [REQ_W-1:0]     req_blocks,
	input  logic [ADDR_IN_W-1:0] free_start,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output status_t              status,
	output logic [START_W-1:0]   start_block
);

	localparam int AW = $clog2(HEAP_BLOCKS);
	localparam int SW = ((AW > LEN_W) ? AW : LEN_W) + 1;
	localparam logic [AW-1:0] LAST = AW'(HEAP_BLOCKS - 1);

	// Memories: one free bit per block, one length per allocation start.
	logic             free_mem_q [HEAP_BLOCKS];
	logic [LEN_W-1:0] len_mem_q  [HEAP_BLOCKS];
	logic             free_rd_q;
	logic [LEN_W-1:0] len_rd_q;

	// Request holding registers and counters.
	op_t                  op_q;
	logic [LEN_W-1:0]     n_q;
	logic [ADDR_IN_W-1:0] fs_q;
	logic [AW-1:0]        chk_q;
	logic [AW-1:0]        ptr_q;
	logic [LEN_W-1:0]     run_q;
	logic [AW-1:0]        start_q;
	status_t              res_status_q;
	logic [START_W-1:0]   res_start_q;

	logic [LEN_W:0]   run_inc;
	logic [AW:0]      nxt_rd;
	logic [SW-1:0]    s_full;
	logic [AW-1:0]    s_idx;
	logic [AW-1:0]    fs_idx;
	logic             hit;
	logic             free_we, free_wd, free_re;
	logic [AW-1:0]    free_ra;
	logic             len_we;
	logic [AW-1:0]    len_wa;
	logic [LEN_W-1:0] len_wd;

	// Run tracking and the start of a run that has just reached the size.
	always_comb begin
		run_inc = {1'b0, run_q} + (LEN_W+1)'(1);
		nxt_rd  = {1'b0, chk_q} + (AW+1)'(1);
		s_full  = SW'(chk_q) + SW'(1) - SW'(n_q);
		s_idx   = s_full[AW-1:0];
		fs_idx  = AW'(fs_q);
		hit     = free_rd_q && (run_inc == {1'b0, n_q});
	end

	// Status toward the controller.
	always_comb begin
		sts.is_free   = (op_q == OP_FREE);
		sts.zero      = (n_q == '0);
		sts.too_big   = (32'(n_q) > 32'(HEAP_BLOCKS));
		sts.bad_addr  = (32'(fs_q) >= 32'(HEAP_BLOCKS));
		sts.hit       = hit;
		sts.scan_last = (chk_q == LAST);
		sts.mark_last = (ptr_q == chk_q);
		sts.len_zero  = (len_rd_q == '0);
		sts.rel_last  = (run_q == LEN_W'(1)) || (ptr_q == LAST);
		sts.clr_last  = (ptr_q == LAST);
	end

	// Free map port control: all writes go through the sweep pointer.
	always_comb begin
		free_we = cmd.clr_step || cmd.mark_step || cmd.rel_step;
		free_wd = !cmd.mark_step;
		free_re = cmd.scan_start || (cmd.scan_step && (32'(nxt_rd) < 32'(HEAP_BLOCKS)));
		free_ra = cmd.scan_start ? '0 : nxt_rd[AW-1:0];
	end

	// Length table port control.
	always_comb begin
		len_we = cmd.clr_step || cmd.len_clear || (cmd.scan_step && hit);
		len_wd = cmd.scan_step ? n_q : '0;
		priority if (cmd.clr_step) begin
			len_wa = ptr_q;
		end else if (cmd.len_clear) begin
			len_wa = fs_idx;
		end else begin
			len_wa = s_idx;
		end
	end

	// Free map memory with registered read.
	always_ff @(posedge clk) begin
		if (free_we) free_mem_q[ptr_q] <= free_wd;
		if (free_re) free_rd_q <= free_mem_q[free_ra];
	end

	// Length memory with registered read.
	always_ff @(posedge clk) begin
		if (len_we) len_mem_q[len_wa] <= len_wd;
		if (cmd.len_rd) len_rd_q <= len_mem_q[fs_idx];
	end

	// Sweep pointer; it starts at block zero for the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else begin
			priority if (cmd.scan_step && hit) begin
				ptr_q <= s_idx;
			end else if (cmd.len_clear) begin
				ptr_q <= fs_idx;
			end else if (cmd.clr_step || cmd.mark_step || cmd.rel_step) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	// Request fields, scan position, run or remaining count, result.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(op);
			n_q  <= req_blocks;
			fs_q <= free_start;
		end
		if (cmd.scan_start) begin
			chk_q <= '0;
			run_q <= '0;
		end else if (cmd.scan_step) begin
			if (hit) begin
				start_q <= s_idx;
			end else begin
				chk_q <= chk_q + AW'(1);
			end
			run_q <= free_rd_q ? run_inc[LEN_W-1:0] : '0;
		end else if (cmd.len_clear) begin
			run_q <= len_rd_q;
		end else if (cmd.rel_step) begin
			run_q <= run_q - LEN_W'(1);
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_start_q  <= cmd.res_grant ? START_W'(start_q) : '0;
		end
	end

	assign status      = res_status_q;
	assign start_block = res_start_q;

endmodule

// ----- rtl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// First-fit block allocator
// Hands out and takes back runs of equal heap blocks, lowest address first.
// ----------------------------------------------------------------------------
// Requests arrive on req (op, req_blocks, free_start) and each one yields
// exactly one response on rsp (status, start_block), in request order.
// An allocate walks the free map one block per cycle from block zero until a
// free run of req_blocks blocks ends at block e, then marks the run one block
// per cycle. A free reads the length table and releases one block per cycle.
// Zero-size, oversized and out-of-range requests go straight to the response
// without a scan or sweep. One request is in progress at a time; req.ready
// is high only while idle. After arst_n the block runs a clearing pass that
// marks every block free and every length empty; req.ready stays low until
// it ends. Responses sit in an output register; a new request is taken while
// an earlier response waits, and if rsp stalls the next result is held until
// the register frees up.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int HEAP_BLOCKS = HEAP_BLOCKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ffba_req_if.sink      req,
	ffba_rsp_if.source    rsp
);

	cmd_t    cmd;
	sts_t    sts;
	status_t res_status;

	// Controller.
	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath.
	ffba_dp #(
		.HEAP_BLOCKS (HEAP_BLOCKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (req.op),
		.req_blocks  (req.req_blocks),
		.free_start  (req.free_start),
		.cmd         (cmd),
		.sts         (sts),
		.status      (res_status),
		.start_block (rsp.start_block)
	);

	assign rsp.status = res_status;

	// Checks on sequencing and result consistency.
	`FFBA_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "request accepted while busy")
	`FFBA_ASSERT_NOW(a_clear_holds_req, cmd.clr_step, !req.ready, "request taken during clearing pass")
	`FFBA_ASSERT_NOW(a_err_start_zero, rsp.valid && (rsp.status != ST_OK), rsp.start_block == '0, "nonzero start on error")
	`FFBA_ASSERT_NOW(a_start_in_heap, rsp.valid, 32'(rsp.start_block) < 32'(HEAP_BLOCKS), "start block beyond heap")

endmodule

// ----- dv/ffba_checker.sv -----
// ----------------------------------------------------------------------------
// First-fit block allocator checker
// Watches the request and response channels, keeps its own copy of the
// free map and the length table, works out the response to each request
// and compares every response with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ffba_checker
	import ffba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ffba_req_if         req,
	ffba_rsp_if         rsp,
	output int unsigned fail_cnt,
	output int unsigned pending
);

	typedef struct packed {
		status_t            status;
		logic [START_W-1:0] start_block;
	} alloc_rsp_t;

	// Shadow heap: one free bit per block, allocation length at each start.
	bit               blk_free [HEAP_BLOCKS_DEF] = '{default: 1'b1};
	logic [LEN_W-1:0] run_len  [HEAP_BLOCKS_DEF] = '{default: '0};

	alloc_rsp_t  due_q[$];
	int unsigned errs = 0;

	// First fit: the lowest run of n free blocks is taken and recorded.
	function automatic alloc_rsp_t grant_run(input logic [REQ_W-1:0] n);
		alloc_rsp_t r;
		int run;
		int s;
		r.status      = ST_NOFIT;
		r.start_block = '0;
		run           = 0;
		if (n == 0) begin
			r.status = ST_ZERO;
			return r;
		end
		if (n > HEAP_BLOCKS_DEF)
			return r;
		for (int i = 0; i < HEAP_BLOCKS_DEF; i++) begin
			if (blk_free[i]) begin
				run++;
				if (run == n) begin
					s = i + 1 - n;
					for (int k = s; k <= i; k++)
						blk_free[k] = 1'b0;
					run_len[s]    = n;
					r.status      = ST_OK;
					r.start_block = s[START_W-1:0];
					return r;
				end
			end else begin
				run = 0;
			end
		end
		return r;
	endfunction

	// A free must name a live allocation start; its blocks go back to the map.
	function automatic alloc_rsp_t return_run(input logic [ADDR_IN_W-1:0] a);
		alloc_rsp_t r;
		int len;
		r.status      = ST_BADADR;
		r.start_block = '0;
		if (a >= HEAP_BLOCKS_DEF)
			return r;
		if (run_len[a] == 0)
			return r;
		len = int'(run_len[a]);
		for (int k = 0; k < len && a + k < HEAP_BLOCKS_DEF; k++)
			blk_free[a + k] = 1'b1;
		run_len[a] = '0;
		r.status   = ST_OK;
		return r;
	endfunction

	// Predict on each accepted request, compare on each accepted response.
	always @(posedge clk) begin
		alloc_rsp_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				if (req.op == OP_ALLOC)
					due_q.push_back(grant_run(req.req_blocks));
				else
					due_q.push_back(return_run(req.free_start));
			end
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					$error("response with no request outstanding: status %0d start_block %0d",
						rsp.status, rsp.start_block);
					errs++;
				end else begin
					want = due_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						errs++;
					end
					if (rsp.start_block !== want.start_block) begin
						$error("start_block: expected %0d, actual %0d",
							want.start_block, rsp.start_block);
						errs++;
					end
				end
			end
		end
		fail_cnt <= errs;
		pending  <= due_q.size();
	end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// First-fit block allocator testbench
// Drives allocate and free requests into the allocator, first a directed
// set of corner cases and then random traffic whose frees mostly name live
// allocations, under varying stalls on both channels. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import ffba_pkg::*;

	logic clk;
	logic arst_n;

	ffba_req_if req_ch ();
	ffba_rsp_if rsp_ch ();

	int unsigned fail_cnt;
	int unsigned pending;

	// Idle rates in percent for the request and response sides.
	int unsigned send_idle;
	int unsigned rcv_idle;
	int unsigned n_sent;

	// Operations in flight and the starts of allocations believed live.
	op_t                sent_op_q[$];
	logic [START_W-1:0] live_q[$];

	first_fit_block_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ffba_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.fail_cnt (fail_cnt),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog against a hung block.
	initial begin
		#100_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Response side: random stalls, and note which allocations succeeded.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready && sent_op_q.size() != 0) begin
			if (sent_op_q.pop_front() == OP_ALLOC && rsp_ch.status == ST_OK)
				live_q.push_back(rsp_ch.start_block);
		end
		rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
	end

	// Send one request, with random idle cycles ahead of it.
	task automatic send_req(input op_t op, input logic [REQ_W-1:0] nblk,
			input logic [ADDR_IN_W-1:0] adr);
		if (n_sent < 200) begin
			send_idle = 8;
			rcv_idle  = 87;
		end else if (n_sent < 400) begin
			send_idle = 87;
			rcv_idle  = 8;
		end else begin
			send_idle = 0;
			rcv_idle  = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.req_blocks <= nblk;
		req_ch.free_start <= adr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent_op_q.push_back(op);
		n_sent++;
	endtask

	// The unused field of each request carries random bits.
	task automatic alloc(input int unsigned nblk);
		send_req(OP_ALLOC, REQ_W'(nblk), ADDR_IN_W'($urandom_range(0, 2047)));
	endtask

	task automatic free_at(input int unsigned adr);
		send_req(OP_FREE, REQ_W'($urandom_range(0, 2047)), ADDR_IN_W'(adr));
	endtask

	// Mostly small sizes keep the scans short; a few zero, huge or large ones.
	function automatic int unsigned pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 2)
			return 0;
		if (r < 5)
			return $urandom_range(HEAP_BLOCKS_DEF + 1, 2047);
		if (r < 8)
			return $urandom_range(65, HEAP_BLOCKS_DEF);
		if (r < 25)
			return $urandom_range(17, 64);
		return $urandom_range(1, 16);
	endfunction

	initial begin
		req_ch.valid      = 1'b0;
		req_ch.op         = OP_ALLOC;
		req_ch.req_blocks = '0;
		req_ch.free_start = '0;
		send_idle         = 8;
		rcv_idle          = 87;
		n_sent            = 0;
		arst_n            = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Zero size, oversized requests and frees out of range or never allocated.
		alloc(0);
		alloc(HEAP_BLOCKS_DEF + 1);
		alloc(2047);
		free_at(HEAP_BLOCKS_DEF);
		free_at(2047);
		free_at(0);

		// The whole heap in one allocation, then a double free.
		alloc(HEAP_BLOCKS_DEF);
		alloc(1);
		free_at(0);
		free_at(0);

		// The top block as an allocation start, then a full heap.
		alloc(HEAP_BLOCKS_DEF - 1);
		alloc(1);
		alloc(1);
		free_at(HEAP_BLOCKS_DEF - 1);
		free_at(0);

		// Holes get refilled first fit; a free that names no allocation start is refused.
		alloc(3);
		alloc(5);
		alloc(2);
		free_at(3);
		free_at(4);
		alloc(4);
		alloc(2);
		alloc(1);
		free_at(0);
		free_at(8);
		free_at(3);
		free_at(7);
		free_at(10);

		// Random traffic: mostly frees of live allocations and small allocations.
		for (int k = 0; k < 552; k++) begin
			int r;
			int idx;
			logic [START_W-1:0] a;
			r = $urandom_range(99);
			if (r < 4) begin
				free_at($urandom_range(0, 2047));
			end else if (live_q.size() != 0 && r < (live_q.size() > 40 ? 80 : 45)) begin
				idx = $urandom_range(0, live_q.size() - 1);
				a   = live_q[idx];
				live_q.delete(idx);
				free_at(32'(a));
			end else begin
				alloc(pick_size());
			end
		end
		req_ch.valid <= 1'b0;

		// Drain the outstanding responses, then watch for stray ones.
		@(posedge clk);
		for (int c = 0; c < 200000 && pending != 0; c++)
			@(posedge clk);
		repeat (2100) @(posedge clk);

		if (pending != 0)
			$error("%0d responses never arrived", pending);
		if (fail_cnt == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
